// ===== src/dhcs_pkg.sv =====
// Package for the degenerate hex cell split block.
// Holds the word types, cell kind codes and the pyramid vertex table; no dependencies.
package dhcs_pkg;

	localparam int unsigned IDX_W = 32;

	typedef enum logic [1:0] {
		KIND_HEX     = 2'd0,
		KIND_WEDGE   = 2'd1,
		KIND_PYRAMID = 2'd2,
		KIND_TET     = 2'd3
	} kind_t;

	typedef struct packed {
		logic [IDX_W-1:0] bottom_corner_0;
		logic [IDX_W-1:0] bottom_corner_1;
		logic [IDX_W-1:0] bottom_corner_2;
		logic [IDX_W-1:0] bottom_corner_3;
		logic [IDX_W-1:0] top_corner_0;
		logic [IDX_W-1:0] top_corner_1;
		logic [IDX_W-1:0] top_corner_2;
		logic [IDX_W-1:0] top_corner_3;
	} in_word_t;

	typedef struct packed {
		logic [1:0]       cell_kind;
		logic [3:0]       vertex_count;
		logic [IDX_W-1:0] vertex_a;
		logic [IDX_W-1:0] vertex_b;
		logic [IDX_W-1:0] vertex_c;
		logic [IDX_W-1:0] vertex_d;
		logic [IDX_W-1:0] vertex_e;
		logic [IDX_W-1:0] vertex_f;
		logic [IDX_W-1:0] vertex_g;
		logic [IDX_W-1:0] vertex_h;
		logic             last_cell;
	} out_word_t;

	// Entries pick corners: 0..3 are bottom, 4..7 are top.
	function automatic logic [2:0] pyr_entry(input logic [1:0] row, input logic [1:0] col);
		logic [2:0] e;
		e = 3'd0;
		case ({row, col})
			4'h0: e = 3'd1; 4'h1: e = 3'd5; 4'h2: e = 3'd7; 4'h3: e = 3'd3;
			4'h4: e = 3'd0; 4'h5: e = 3'd2; 4'h6: e = 3'd6; 4'h7: e = 3'd4;
			4'h8: e = 3'd1; 4'h9: e = 3'd3; 4'hA: e = 3'd7; 4'hB: e = 3'd5;
			4'hC: e = 3'd0; 4'hD: e = 3'd4; 4'hE: e = 3'd6; 4'hF: e = 3'd2;
			default: e = 3'd0;
		endcase
		return e;
	endfunction

endpackage

// ===== src/degenerate_hex_cell_split_core.sv =====
// Channel | valid     | stall     | word
// input   | in_valid  | in_stall  | in_word  (in_word_t)
// output  | out_valid | out_stall | out_word (out_word_t)
// Three register stages: compare, classify, build; the output is shown from the build stage.
// One word a cycle unless stalled; a two-cell column holds the last stage until both cells leave.
// A stalled valid output freezes every stage together; nothing is lost or repeated.
// Reset clears all valid bits asynchronously.
// Depends on dhcs_pkg, dhcs_classify, dhcs_build, dhcs_emit.
module degenerate_hex_cell_split_core import dhcs_pkg::*; #(
	parameter int unsigned INDEX_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_word_t  in_word,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_word
);
	logic                  en, valid_s2, ok_s2;
	logic [3:0]            col_s2;
	logic [3:0][IDX_W-1:0] b_s2, t_s2;
	logic [1:0]            cnt_s3;
	out_word_t             first_s3, second_s3;

	assign in_stall = !en;

	dhcs_classify #(.INDEX_BITS(INDEX_BITS)) u_cls (
		.clk, .arst_n, .en, .in_valid, .in_word,
		.valid_s2, .ok_s2, .col_s2, .b_s2, .t_s2
	);

	dhcs_build u_bld (
		.clk, .arst_n, .en, .valid_s2, .ok_s2, .col_s2, .b_s2, .t_s2,
		.cnt_s3, .first_s3, .second_s3
	);

	dhcs_emit u_emit (
		.clk, .arst_n, .cnt_s3, .first_s3, .second_s3,
		.en, .out_valid, .out_word, .out_stall
	);

endmodule

// ===== src/dhcs_classify.sv =====
// Stages 1 and 2: masks corner indices, compares them and registers the collapse pattern.
// Depends on dhcs_pkg.
module dhcs_classify import dhcs_pkg::*; #(
	parameter int unsigned INDEX_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  in_word_t              in_word,
	output logic                  valid_s2,
	output logic                  ok_s2,
	output logic [3:0]            col_s2,
	output logic [3:0][IDX_W-1:0] b_s2,
	output logic [3:0][IDX_W-1:0] t_s2
);
	// Indices keep only their low INDEX_BITS bits; wider settings keep the whole word.
	localparam logic [IDX_W-1:0] IDX_MASK = (INDEX_BITS >= IDX_W) ? {IDX_W{1'b1}} :
		IDX_W'((64'd1 << INDEX_BITS) - 64'd1);

	logic [3:0][IDX_W-1:0] b_s1, t_s1;
	logic                  valid_s1;
	logic [3:0][IDX_W-1:0] b_in, t_in;
	logic [15:0]           eq_bb, eq_tt, eq_tb;
	logic [15:0]           eq_bb_s1, eq_tt_s1, eq_tb_s1;
	logic                  bad;

	always_comb begin
		b_in[0] = in_word.bottom_corner_0 & IDX_MASK;
		b_in[1] = in_word.bottom_corner_1 & IDX_MASK;
		b_in[2] = in_word.bottom_corner_2 & IDX_MASK;
		b_in[3] = in_word.bottom_corner_3 & IDX_MASK;
		t_in[0] = in_word.top_corner_0 & IDX_MASK;
		t_in[1] = in_word.top_corner_1 & IDX_MASK;
		t_in[2] = in_word.top_corner_2 & IDX_MASK;
		t_in[3] = in_word.top_corner_3 & IDX_MASK;
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				eq_bb[i*4+j] = (b_in[i] == b_in[j]);
				eq_tt[i*4+j] = (t_in[i] == t_in[j]);
				eq_tb[i*4+j] = (t_in[i] == b_in[j]);
			end
		end
	end

	always_comb begin
		bad = 1'b0;
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				if (i != j && (eq_bb_s1[i*4+j] || eq_tt_s1[i*4+j] || eq_tb_s1[i*4+j])) begin
					bad = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b_s1     <= b_in;
			t_s1     <= t_in;
			eq_bb_s1 <= eq_bb;
			eq_tt_s1 <= eq_tt;
			eq_tb_s1 <= eq_tb;
			b_s2     <= b_s1;
			t_s2     <= t_s1;
			ok_s2    <= !bad;
			col_s2   <= {eq_tb_s1[15], eq_tb_s1[10], eq_tb_s1[5], eq_tb_s1[0]};
		end
	end

endmodule

// ===== src/dhcs_build.sv =====
// Stage 3: builds up to two cell words from the collapse pattern and the corners.
// Depends on dhcs_pkg.
module dhcs_build import dhcs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  valid_s2,
	input  logic                  ok_s2,
	input  logic [3:0]            col_s2,
	input  logic [3:0][IDX_W-1:0] b_s2,
	input  logic [3:0][IDX_W-1:0] t_s2,
	output logic [1:0]            cnt_s3,
	output out_word_t             first_s3,
	output out_word_t             second_s3
);
	logic [1:0]             cnt;
	out_word_t              w0, w1;
	logic [7:0][IDX_W-1:0]  all;
	logic [3:0][IDX_W-1:0]  b, t;
	logic [1:0]             c, u;
	logic [2:0]             k;

	function automatic out_word_t mk(input kind_t kd, input logic [3:0] n,
			input logic [7:0][IDX_W-1:0] v, input logic last);
		out_word_t r;
		r.cell_kind    = kd;
		r.vertex_count = n;
		r.vertex_a = v[0]; r.vertex_b = v[1]; r.vertex_c = v[2]; r.vertex_d = v[3];
		r.vertex_e = v[4]; r.vertex_f = v[5]; r.vertex_g = v[6]; r.vertex_h = v[7];
		r.last_cell = last;
		return r;
	endfunction

	always_comb begin
		logic [7:0][IDX_W-1:0] v;
		for (int i = 0; i < 4; i++) begin
			b[i] = b_s2[i];
			t[i] = t_s2[i];
			all[i] = b[i];
			all[i+4] = t[i];
		end
		c = 2'd0;
		u = 2'd0;
		for (int i = 0; i < 4; i++) begin
			if (col_s2[i]) c = 2'(i);
			if (!col_s2[i]) u = 2'(i);
		end
		cnt = 2'd0;
		v = '0;
		w0 = mk(KIND_HEX, 4'd8, all, 1'b1);
		w1 = w0;
		k = 3'd0;
		case (col_s2)
			4'b0000: cnt = 2'd1;
			4'b0001, 4'b0010, 4'b0100, 4'b1000: begin
				for (int i = 0; i < 4; i++) begin
					if (2'(i) != c) begin
						v[k]        = t[i];
						v[k + 3'd3] = b[i];
						k = k + 3'd1;
					end
				end
				w0 = mk(KIND_WEDGE, 4'd6, v, 1'b0);
				v = '0;
				for (int i = 0; i < 4; i++) v[i] = all[pyr_entry(c, 2'(i))];
				v[4] = b[c];
				w1 = mk(KIND_PYRAMID, 4'd5, v, 1'b1);
				cnt = 2'd2;
			end
			4'b0101: begin
				v[0] = b[0]; v[1] = b[1]; v[2] = b[2]; v[3] = t[1];
				w0 = mk(KIND_TET, 4'd4, v, 1'b0);
				v[0] = b[0]; v[1] = b[2]; v[2] = b[3]; v[3] = t[3];
				w1 = mk(KIND_TET, 4'd4, v, 1'b1);
				cnt = 2'd2;
			end
			4'b1010: begin
				v[0] = b[0]; v[1] = b[1]; v[2] = b[3]; v[3] = t[0];
				w0 = mk(KIND_TET, 4'd4, v, 1'b0);
				v[0] = b[1]; v[1] = b[2]; v[2] = b[3]; v[3] = t[2];
				w1 = mk(KIND_TET, 4'd4, v, 1'b1);
				cnt = 2'd2;
			end
			4'b0011: begin
				v[0] = b[1]; v[1] = b[2]; v[2] = t[2]; v[3] = b[0]; v[4] = b[3]; v[5] = t[3];
				w0 = mk(KIND_WEDGE, 4'd6, v, 1'b1);
				cnt = 2'd1;
			end
			4'b0110: begin
				v[0] = b[2]; v[1] = b[3]; v[2] = t[3]; v[3] = b[1]; v[4] = b[0]; v[5] = t[0];
				w0 = mk(KIND_WEDGE, 4'd6, v, 1'b1);
				cnt = 2'd1;
			end
			4'b1100: begin
				v[0] = b[3]; v[1] = b[0]; v[2] = t[0]; v[3] = b[2]; v[4] = b[1]; v[5] = t[1];
				w0 = mk(KIND_WEDGE, 4'd6, v, 1'b1);
				cnt = 2'd1;
			end
			4'b1001: begin
				v[0] = b[0]; v[1] = b[1]; v[2] = t[1]; v[3] = b[3]; v[4] = b[2]; v[5] = t[2];
				w0 = mk(KIND_WEDGE, 4'd6, v, 1'b1);
				cnt = 2'd1;
			end
			4'b0111, 4'b1011, 4'b1101, 4'b1110: begin
				v[0] = b[u - 2'd1]; v[1] = b[u]; v[2] = b[u + 2'd1]; v[3] = t[u];
				w0 = mk(KIND_TET, 4'd4, v, 1'b1);
				cnt = 2'd1;
			end
			default: cnt = 2'd0;
		endcase
		if (!valid_s2 || !ok_s2) cnt = 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s3 <= 2'd0;
		end else if (en) begin
			cnt_s3 <= cnt;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			first_s3  <= w0;
			second_s3 <= w1;
		end
	end

endmodule

// ===== src/dhcs_emit.sv =====
// Output side: holds stage 3 words and sends one or two cells, one a cycle unless stalled.
// Depends on dhcs_pkg.
module dhcs_emit import dhcs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic [1:0] cnt_s3,
	input  out_word_t first_s3,
	input  out_word_t second_s3,
	output logic      en,
	output logic      out_valid,
	output out_word_t out_word,
	input  logic      out_stall
);
	logic       sent_first_q;
	logic       ldone;

	// Stage 3 holds until its last cell leaves; the word is shown straight from it.
	assign out_valid = (cnt_s3 != 2'd0);
	assign out_word  = (sent_first_q) ? second_s3 : first_s3;
	assign ldone     = out_valid && !out_stall && (cnt_s3 == 2'd1 || sent_first_q);
	assign en        = !out_valid || ldone;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_first_q <= 1'b0;
		end else if (out_valid && !out_stall) begin
			sent_first_q <= !ldone;
		end
	end

endmodule

// ===== src/dhcs_checker.sv =====
// Port-level checks on the split core's output channel.
// Depends on dhcs_pkg; bound to degenerate_hex_cell_split_core.
module dhcs_checker import dhcs_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_stall,
	input out_word_t out_word
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word)) else $error("stalled word changed");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_word.vertex_count == 4'd8 || out_word.vertex_count == 4'd6 ||
		out_word.vertex_count == 4'd5 || out_word.vertex_count == 4'd4) else $error("bad count");
	a_pyr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && out_word.cell_kind == KIND_WEDGE && !out_word.last_cell
		|=> out_valid && out_word.cell_kind == KIND_PYRAMID) else $error("pyramid missing");
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.vertex_count == 4'd4 |-> out_word.vertex_e == '0 &&
		out_word.vertex_h == '0) else $error("unused slot not zero");
endmodule

bind degenerate_hex_cell_split_core dhcs_checker u_chk (
	.clk, .arst_n, .out_valid, .out_stall, .out_word
);
